### rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the program map section parser: record
// kinds, register indexes, the record bundle passed from parser to emitter.
// ----------------------------------------------------------------------------
package pss_pkg;

	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] KIND_STREAM    = 2'd0;
	localparam logic [1:0] KIND_PROG_CA   = 2'd1;
	localparam logic [1:0] KIND_STREAM_CA = 2'd2;
	localparam logic [1:0] KIND_END       = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_CA_TAG   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LANG_TAG = CFG_IDX_W'(1);

	localparam logic [7:0] CA_TAG_RESET   = 8'd9;
	localparam logic [7:0] LANG_TAG_RESET = 8'd10;

	// record slots of one bundle, in delivery order
	localparam int REC_CA  = 0;
	localparam int REC_ST  = 1;
	localparam int REC_END = 2;
	localparam int REC_N   = 3;

	typedef struct packed {
		logic [REC_N-1:0] recs;
		logic             ca_in_stream;
		logic [7:0]       es_type;
		logic [12:0]      pid;
		logic [23:0]      lang;
		logic [15:0]      ca_id;
		logic [12:0]      ecm;
		logic [7:0]       count;
		logic             err;
	} pss_bundle_t;

	typedef enum logic [8:0] {
		PH_IDLE   = 9'b000000001,
		PH_HDR1   = 9'b000000010,
		PH_HDR2   = 9'b000000100,
		PH_FIXED  = 9'b000001000,
		PH_PROG   = 9'b000010000,
		PH_ESHDR  = 9'b000100000,
		PH_ESDESC = 9'b001000000,
		PH_CRC    = 9'b010000000,
		PH_DONE   = 9'b100000000
	} pss_phase_t;

endpackage

### rtl/pss_front.sv
// ----------------------------------------------------------------------------
// pss_front
// Byte parser: walks the section header, program descriptor loop and
// elementary stream loop, and turns each byte into a bundle of up to three
// records (stream CA or program CA, stream entry, section end).
// ----------------------------------------------------------------------------
module pss_front import pss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           section_byte,
	input  logic                 section_start,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output logic                 bnd_push,
	output pss_bundle_t          bnd
);

	logic [7:0] ca_tag_q, lang_tag_q;

	pss_phase_t phase_q, n_phase;
	logic [11:0] pos_q, n_pos, sec_len_q, n_sec_len, loop_q, n_loop;
	logic [7:0]  tag_q, n_tag, drem_q, n_drem, idx_q, n_idx;
	logic [7:0]  type_q, n_type, streams_q, n_streams;
	logic [12:0] pid_q, n_pid, ecm_q, n_ecm;
	logic [23:0] lang_q, n_lang;
	logic [15:0] ca_q, n_ca;
	logic        lseen_q, n_lseen, over_q, n_over;
	logic        rec_ca, rec_st, rec_end, ca_stream;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ca_tag_q   <= CA_TAG_RESET;
			lang_tag_q <= LANG_TAG_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_CA_TAG) ca_tag_q <= cfg_data;
			if (cfg_index == REG_LANG_TAG) lang_tag_q <= cfg_data;
		end
	end

	always_comb begin
		logic [7:0]  b;
		logic [11:0] lim;
		logic [7:0]  k;
		logic        in_stream, ca_done, emit;
		pss_phase_t  ph;

		b         = section_byte;
		lim       = '0;
		k         = '0;
		in_stream = 1'b0;
		ca_done   = 1'b0;
		emit      = 1'b0;
		ph        = phase_q;

		n_phase   = phase_q;
		n_pos     = pos_q;
		n_sec_len = sec_len_q;
		n_loop    = loop_q;
		n_tag     = tag_q;
		n_drem    = drem_q;
		n_idx     = idx_q;
		n_type    = type_q;
		n_pid     = pid_q;
		n_lang    = lang_q;
		n_lseen   = lseen_q;
		n_ca      = ca_q;
		n_ecm     = ecm_q;
		n_streams = streams_q;
		n_over    = over_q;
		rec_ca    = 1'b0;
		rec_st    = 1'b0;
		rec_end   = 1'b0;
		ca_stream = 1'b0;

		if (accept) begin
			if (section_start) begin
				n_phase   = PH_HDR1;
				n_pos     = '0;
				n_sec_len = '0;
				n_loop    = '0;
				n_tag     = '0;
				n_drem    = '0;
				n_idx     = '0;
				n_type    = '0;
				n_pid     = '0;
				n_lang    = '0;
				n_lseen   = 1'b0;
				n_ca      = '0;
				n_ecm     = '0;
				n_streams = '0;
				n_over    = 1'b0;
			end else begin
				case (phase_q)
					PH_HDR1: begin
						n_sec_len = {b[3:0], 8'h00};
						n_phase   = PH_HDR2;
					end
					PH_HDR2: begin
						n_sec_len = sec_len_q | {4'h0, b};
						n_pos     = '0;
						if (n_sec_len == '0) begin
							n_over  = 1'b1;
							rec_end = 1'b1;
							n_phase = PH_DONE;
						end else begin
							n_phase = PH_FIXED;
						end
					end
					PH_FIXED, PH_PROG, PH_ESHDR, PH_ESDESC, PH_CRC: begin
						lim = (sec_len_q >= 12'd4) ? sec_len_q - 12'd4 : 12'd0;
						// cut the open item once the CRC region is reached
						if (pos_q >= lim && phase_q != PH_CRC) begin
							if (phase_q == PH_FIXED || phase_q == PH_PROG ||
							    phase_q == PH_ESDESC)
								n_over = 1'b1;
							if (phase_q == PH_ESHDR && idx_q != 8'd0) n_over = 1'b1;
							if (phase_q == PH_ESDESC) emit = 1'b1;
							ph = PH_CRC;
						end

						if (ph == PH_PROG || ph == PH_ESDESC) begin
							in_stream = (ph == PH_ESDESC);
							if (idx_q == 8'd0) begin
								n_tag = b;
								n_idx = 8'd1;
							end else if (idx_q == 8'd1) begin
								n_drem = b;
								if (b == 8'd0) begin
									if (in_stream && tag_q == lang_tag_q) n_lseen = 1'b1;
									n_idx = 8'd0;
								end else begin
									n_idx = 8'd2;
								end
							end else begin
								k = idx_q - 8'd2;
								if (tag_q == ca_tag_q) begin
									case (k)
										8'd0: n_ca = {b, 8'h00};
										8'd1: n_ca = {ca_q[15:8], b};
										8'd2: n_ecm = {b[4:0], 8'h00};
										8'd3: begin
											n_ecm   = {ecm_q[12:8], b};
											ca_done = 1'b1;
										end
										default: ;
									endcase
								end
								if (in_stream && tag_q == lang_tag_q && !lseen_q) begin
									case (k)
										8'd0: n_lang[23:16] = lang_q[23:16] | b;
										8'd1: n_lang[15:8]  = lang_q[15:8] | b;
										8'd2: n_lang[7:0]   = lang_q[7:0] | b;
										default: ;
									endcase
								end
								n_drem = drem_q - 8'd1;
								if (n_drem == 8'd0) begin
									if (in_stream && tag_q == lang_tag_q) n_lseen = 1'b1;
									n_idx = 8'd0;
								end else if (idx_q != 8'hFF) begin
									n_idx = idx_q + 8'd1;
								end
							end
							if (ca_done) begin
								rec_ca    = 1'b1;
								ca_stream = in_stream;
							end
							n_loop = loop_q - 12'd1;
							if (n_loop == '0) begin
								if (n_idx != 8'd0) n_over = 1'b1;
								n_idx = 8'd0;
								if (in_stream) emit = 1'b1;
								ph = PH_ESHDR;
							end
						end else if (ph == PH_FIXED) begin
							if (pos_q == 12'd7) begin
								n_loop = {b[3:0], 8'h00};
							end else if (pos_q == 12'd8) begin
								n_loop = loop_q | {4'h0, b};
								n_idx  = 8'd0;
								ph     = (n_loop != '0) ? PH_PROG : PH_ESHDR;
							end
						end else if (ph == PH_ESHDR) begin
							case (idx_q)
								8'd0: begin
									n_type  = b;
									n_pid   = '0;
									n_lang  = '0;
									n_lseen = 1'b0;
								end
								8'd1: n_pid = {b[4:0], 8'h00};
								8'd2: n_pid = pid_q | {5'h00, b};
								8'd3: n_loop = {b[3:0], 8'h00};
								default: n_loop = loop_q | {4'h0, b};
							endcase
							if (idx_q >= 8'd4) begin
								n_idx = 8'd0;
								if (n_loop == '0) emit = 1'b1;
								else ph = PH_ESDESC;
							end else begin
								n_idx = idx_q + 8'd1;
							end
						end

						if (emit) begin
							rec_st = 1'b1;
							if (streams_q != 8'hFF) n_streams = streams_q + 8'd1;
						end
						if ({1'b0, pos_q} + 13'd1 == {1'b0, sec_len_q}) begin
							rec_end = 1'b1;
							ph      = PH_DONE;
						end
						n_pos   = pos_q + 12'd1;
						n_phase = ph;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= '0;
			sec_len_q <= '0;
			loop_q    <= '0;
			tag_q     <= '0;
			drem_q    <= '0;
			idx_q     <= '0;
			type_q    <= '0;
			pid_q     <= '0;
			lang_q    <= '0;
			lseen_q   <= 1'b0;
			ca_q      <= '0;
			ecm_q     <= '0;
			streams_q <= '0;
			over_q    <= 1'b0;
		end else begin
			phase_q   <= n_phase;
			pos_q     <= n_pos;
			sec_len_q <= n_sec_len;
			loop_q    <= n_loop;
			tag_q     <= n_tag;
			drem_q    <= n_drem;
			idx_q     <= n_idx;
			type_q    <= n_type;
			pid_q     <= n_pid;
			lang_q    <= n_lang;
			lseen_q   <= n_lseen;
			ca_q      <= n_ca;
			ecm_q     <= n_ecm;
			streams_q <= n_streams;
			over_q    <= n_over;
		end
	end

	always_comb begin
		bnd.recs                = '0;
		bnd.recs[REC_CA]        = rec_ca;
		bnd.recs[REC_ST]        = rec_st;
		bnd.recs[REC_END]       = rec_end;
		bnd.ca_in_stream        = ca_stream;
		bnd.es_type             = n_type;
		bnd.pid                 = n_pid;
		bnd.lang                = n_lang;
		bnd.ca_id               = n_ca;
		bnd.ecm                 = n_ecm;
		bnd.count               = n_streams;
		bnd.err                 = n_over;
	end

	assign bnd_push = rec_ca | rec_st | rec_end;

endmodule

### rtl/pss_queue.sv
// ----------------------------------------------------------------------------
// pss_queue
// Short first-in first-out buffer of record bundles between parser and
// emitter.
// ----------------------------------------------------------------------------
module pss_queue import pss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  pss_bundle_t din,
	output logic        full,
	input  logic        pop,
	output pss_bundle_t dout,
	output logic        empty
);

	pss_bundle_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wptr_q, rptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push, do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + QPTR_W'(1);
			if (do_pop) rptr_q <= rptr_q + QPTR_W'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

### rtl/pss_back.sv
// ----------------------------------------------------------------------------
// pss_back
// Record emitter: splits each bundle into its records in slot order, bundles
// oldest first, and holds one record in the output register until it is taken.
// ----------------------------------------------------------------------------
module pss_back import pss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  pss_bundle_t q_dout,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  record_kind,
	output logic [7:0]  es_type,
	output logic [12:0] elementary_pid,
	output logic [23:0] language_code,
	output logic [15:0] ca_system_id,
	output logic [12:0] ecm_pid,
	output logic [7:0]  stream_count,
	output logic        length_error,
	output logic        last_of_run
);

	pss_bundle_t      hold_q, src;
	logic [REC_N-1:0] pend_q, src_mask, pick, rest;
	logic             out_v_q, load, use_hold, go;

	assign load     = !out_v_q || pop;
	assign use_hold = (pend_q != '0);
	assign src      = use_hold ? hold_q : q_dout;
	assign src_mask = use_hold ? pend_q : (q_empty ? '0 : q_dout.recs);
	assign pick     = src_mask & (~src_mask + REC_N'(1));
	assign rest     = src_mask & ~pick;
	assign go       = load && (src_mask != '0);
	assign q_pop    = go && !use_hold;
	assign empty    = !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			pend_q  <= '0;
		end else if (go) begin
			out_v_q <= 1'b1;
			pend_q  <= rest;
		end else if (load) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (!use_hold) hold_q <= q_dout;
			record_kind    <= KIND_END;
			es_type        <= '0;
			elementary_pid <= '0;
			language_code  <= '0;
			ca_system_id   <= '0;
			ecm_pid        <= '0;
			stream_count   <= '0;
			length_error   <= 1'b0;
			last_of_run    <= (rest == '0);
			if (pick[REC_CA]) begin
				record_kind  <= src.ca_in_stream ? KIND_STREAM_CA : KIND_PROG_CA;
				ca_system_id <= src.ca_id;
				ecm_pid      <= src.ecm;
				if (src.ca_in_stream) begin
					es_type        <= src.es_type;
					elementary_pid <= src.pid;
				end
			end else if (pick[REC_ST]) begin
				record_kind    <= KIND_STREAM;
				es_type        <= src.es_type;
				elementary_pid <= src.pid;
				language_code  <= src.lang;
			end else begin
				stream_count <= src.count;
				length_error <= src.err;
			end
		end
	end

endmodule

### rtl/pmt_section_stream_parser.sv
// ----------------------------------------------------------------------------
// pmt_section_stream_parser
// Program map section parser: section bytes in, stream / CA / end records out.
// ----------------------------------------------------------------------------
// A section byte is taken on every cycle in which push is high and full is
// low, so a section streams in at one byte per clock. Each byte yields zero
// to three records, and records leave at one per clock while pop is high,
// through a single output register. Bundles of records wait in a four-entry
// queue between the byte parser and the record emitter, so full rises only
// when record output falls behind by more than four record-producing bytes
// (sustained rate: one record per cycle while pop is high). The two
// descriptor tag registers are written at any time through cfg_valid, which
// is always ready; write them while no section is in flight.
module pmt_section_stream_parser import pss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           section_byte,
	input  logic                 section_start,
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           record_kind,
	output logic [7:0]           es_type,
	output logic [12:0]          elementary_pid,
	output logic [23:0]          language_code,
	output logic [15:0]          ca_system_id,
	output logic [12:0]          ecm_pid,
	output logic [7:0]           stream_count,
	output logic                 length_error,
	output logic                 last_of_run,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	pss_bundle_t bnd_in, bnd_out;
	logic        bnd_push, q_full, q_empty, q_pop;

	assign full      = q_full;
	assign cfg_ready = 1'b1;

	pss_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (push && !q_full),
		.section_byte  (section_byte),
		.section_start (section_start),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.bnd_push      (bnd_push),
		.bnd           (bnd_in)
	);

	pss_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (bnd_push),
		.din    (bnd_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (bnd_out),
		.empty  (q_empty)
	);

	pss_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_dout         (bnd_out),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.record_kind    (record_kind),
		.es_type        (es_type),
		.elementary_pid (elementary_pid),
		.language_code  (language_code),
		.ca_system_id   (ca_system_id),
		.ecm_pid        (ecm_pid),
		.stream_count   (stream_count),
		.length_error   (length_error),
		.last_of_run    (last_of_run)
	);

endmodule

### rtl/pss_chk.sv
// ----------------------------------------------------------------------------
// pss_chk
// Port-level checks of the section parser, bound to the top level.
// ----------------------------------------------------------------------------
module pss_chk import pss_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input logic [1:0]           record_kind,
	input logic [12:0]          elementary_pid,
	input logic [23:0]          language_code,
	input logic [15:0]          ca_system_id,
	input logic                 last_of_run
);

	// hold a waiting record until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(record_kind) && $stable(ca_system_id) &&
		$stable(language_code) && $stable(last_of_run))
		else $error("waiting record changed before pop");

	// section end closes the byte's run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && record_kind == KIND_END |-> last_of_run)
		else $error("section end record not last of run");

	// a program CA record never shares a byte with another record
	a_prog_alone: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && record_kind == KIND_PROG_CA |-> last_of_run && elementary_pid == '0)
		else $error("program CA record not alone");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> empty)
		else $error("record visible during reset");

endmodule

bind pmt_section_stream_parser pss_chk u_chk (.*);
